// File: rtl/u8dec_pkg.sv
package u8dec_pkg;

  // Sequence length classes taken from the lead byte.
  typedef enum logic [2:0] {
    LenBad = 3'd0,
    Len1   = 3'd1,
    Len2   = 3'd2,
    Len3   = 3'd3,
    Len4   = 3'd4,
    Len5   = 3'd5,
    Len6   = 3'd6
  } seq_len_e;

  localparam int unsigned NumBytes   = 6;
  localparam int unsigned CpWidth    = 32;
  localparam int unsigned LenWidth   = 3;
  localparam int unsigned InWidth    = 56;
  localparam int unsigned OutWidth   = 40;
  localparam logic [CpWidth-1:0] FailValue = '1;
  localparam logic [2:0] MaxAvail = 3'd6;

  // Decoded fields of one result item.
  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [LenWidth-1:0] skip_length;
    logic                decode_error;
  } dec_result_t;

  // Classify the lead byte.
  function automatic seq_len_e lead_length(input logic [7:0] b);
    seq_len_e len;
    len = LenBad;
    if (b[7] == 1'b0) begin
      len = Len1;
    end else if (b[7:5] == 3'b110) begin
      len = Len2;
    end else if (b[7:4] == 4'b1110) begin
      len = Len3;
    end else if (b[7:3] == 5'b11110) begin
      len = Len4;
    end else if (b[7:2] == 6'b111110) begin
      len = Len5;
    end else if (b[7:1] == 7'b1111110) begin
      len = Len6;
    end
    return len;
  endfunction

endpackage

// File: rtl/utf8_char_decoder_unit.sv
// An accepted input item is held in the input register, and its result is offered on the
// master side from the result register (one input register, one result register).
// Throughput: one item per cycle while the master side is ready; the decode is a single
// pass of mask-and-shift logic.
// Stalls: s_axis_tready_o drops only when both registers hold items and the result waits.
// Reset: rst_ni clears both valid flags at once; the data and result registers are not reset.
module utf8_char_decoder_unit
  import u8dec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // byte_0[7:0], byte_1[15:8], byte_2[23:16], byte_3[31:24], byte_4[39:32],
  // byte_5[47:40], available_bytes[50:48], zero fill [55:51]
  input  logic [InWidth-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // code_point[31:0], skip_length[34:32], decode_error[35], zero fill [39:36]
  output logic [OutWidth-1:0] m_axis_tdata_o
);

  logic               in_vld_q;
  logic [InWidth-1:0] in_data_q;
  logic               out_vld_q;
  dec_result_t        res_q, res_d;
  logic               adv_out;
  logic               adv_in;

  // The result register moves when it is empty or being drained.
  assign adv_out         = !out_vld_q || m_axis_tready_i;
  assign adv_in          = !in_vld_q || adv_out;
  assign s_axis_tready_o = adv_in;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv_in) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  // Decode logic.
  logic [7:0]          bytes_w [NumBytes];
  logic [2:0]          avail_w;
  seq_len_e            len_w;
  logic [NumBytes-1:0] cont_ok_w;
  logic                ok_w;
  logic [CpWidth-1:0]  cp_w;

  always_comb begin
    for (int i = 0; i < NumBytes; i++) begin
      bytes_w[i]   = in_data_q[8*i +: 8];
      cont_ok_w[i] = (bytes_w[i][7:6] == 2'b10);
    end
    avail_w = (in_data_q[50:48] > MaxAvail) ? MaxAvail : in_data_q[50:48];
    len_w   = lead_length(bytes_w[0]);

    ok_w = 1'b0;
    cp_w = '0;
    unique case (len_w)
      Len1: begin
        ok_w = 1'b1;
        cp_w = {25'd0, bytes_w[0][6:0]};
      end
      Len2: begin
        ok_w = cont_ok_w[1];
        cp_w = {21'd0, bytes_w[0][4:0], bytes_w[1][5:0]};
      end
      Len3: begin
        ok_w = &cont_ok_w[2:1];
        cp_w = {16'd0, bytes_w[0][3:0], bytes_w[1][5:0], bytes_w[2][5:0]};
      end
      Len4: begin
        ok_w = &cont_ok_w[3:1];
        cp_w = {11'd0, bytes_w[0][2:0], bytes_w[1][5:0], bytes_w[2][5:0],
                bytes_w[3][5:0]};
      end
      Len5: begin
        ok_w = &cont_ok_w[4:1];
        cp_w = {6'd0, bytes_w[0][1:0], bytes_w[1][5:0], bytes_w[2][5:0],
                bytes_w[3][5:0], bytes_w[4][5:0]};
      end
      Len6: begin
        ok_w = &cont_ok_w[5:1];
        cp_w = {1'b0, bytes_w[0][0], bytes_w[1][5:0], bytes_w[2][5:0],
                bytes_w[3][5:0], bytes_w[4][5:0], bytes_w[5][5:0]};
      end
      default: begin
        ok_w = 1'b0;
        cp_w = '0;
      end
    endcase

    // Too few bytes in the window also fails.
    if (avail_w < len_w) begin
      ok_w = 1'b0;
    end

    if (ok_w) begin
      res_d.code_point   = cp_w;
      res_d.skip_length  = len_w;
      res_d.decode_error = 1'b0;
    end else begin
      res_d.code_point   = FailValue;
      res_d.skip_length  = '0;
      res_d.decode_error = 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_out) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, res_q.decode_error, res_q.skip_length, res_q.code_point};

  // A failed decode always carries the fail value and a zero length.
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.decode_error) |->
      (res_q.code_point == FailValue && res_q.skip_length == '0))
    else $error("error result with wrong fields");

  // A good decode has a length from one to six.
  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_q.decode_error) |->
      (res_q.skip_length != '0 && res_q.skip_length <= MaxAvail))
    else $error("good result with bad length");

  // A stalled result is held until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |=> (out_vld_q && $stable(res_q)))
    else $error("stalled result changed");

  // A full input stage moves forward whenever the result side advances.
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && adv_out) |=> out_vld_q)
    else $error("input item lost");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import u8dec_pkg::*;

  localparam int unsigned CycleLimit = 200_000;

  // One input item as it travels on s_axis_tdata: byte_0 in the lowest bits.
  typedef struct packed {
    logic [4:0]      fill;
    logic [2:0]      available_bytes;
    logic [5:0][7:0] octet;
  } char_window_t;

  // Predicts each decoded character and checks the results in order.
  class decoded_char_board;
    dec_result_t pending_chars[$];
    int unsigned fail_count;

    function dec_result_t decode_window(input char_window_t w);
      dec_result_t res;
      seq_len_e    seq_len;
      int unsigned n;
      int unsigned avail;
      logic        ok;
      logic [31:0] cp;
      casez (w.octet[0])
        8'b0???????: seq_len = Len1;
        8'b110?????: seq_len = Len2;
        8'b1110????: seq_len = Len3;
        8'b11110???: seq_len = Len4;
        8'b111110??: seq_len = Len5;
        8'b1111110?: seq_len = Len6;
        default:     seq_len = LenBad;
      endcase
      n = int'(seq_len);
      // A count of seven means six.
      avail = (w.available_bytes > MaxAvail) ? int'(MaxAvail) : int'(w.available_bytes);
      ok = (seq_len != LenBad) && (avail >= n);
      cp = '0;
      if (ok) begin
        cp = 32'(w.octet[0] & (8'hFF >> ((n == 1) ? 1 : n + 1)));
        for (int i = 1; i < n; i++) begin
          if (w.octet[i][7:6] != 2'b10) ok = 1'b0;
          cp = (cp << 6) | 32'(w.octet[i][5:0]);
        end
      end
      if (ok) begin
        res.code_point   = cp;
        res.skip_length  = 3'(n);
        res.decode_error = 1'b0;
      end else begin
        res.code_point   = FailValue;
        res.skip_length  = '0;
        res.decode_error = 1'b1;
      end
      return res;
    endfunction

    function void note_window(input char_window_t w);
      pending_chars.push_back(decode_window(w));
    endfunction

    function void check_char(input logic [OutWidth-1:0] data);
      dec_result_t want;
      logic [31:0] cp;
      logic [2:0]  skip;
      logic        err;
      cp   = data[31:0];
      skip = data[34:32];
      err  = data[35];
      if (pending_chars.size() == 0) begin
        $error("result item with nothing expected: code_point %h", cp);
        fail_count++;
        return;
      end
      want = pending_chars.pop_front();
      if (cp !== want.code_point) begin
        $error("code_point: expected %h, actual %h", want.code_point, cp);
        fail_count++;
      end
      if (skip !== want.skip_length) begin
        $error("skip_length: expected %0d, actual %0d", want.skip_length, skip);
        fail_count++;
      end
      if (err !== want.decode_error) begin
        $error("decode_error: expected %0b, actual %0b", want.decode_error, err);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_valid = 1'b0;
  logic [InWidth-1:0] s_data = '0;
  logic               m_ready = 1'b0;
  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic [OutWidth-1:0] m_axis_tdata_o;

  int unsigned        src_idle_pct = 22;
  int unsigned        sink_idle_pct = 73;
  int unsigned        cycle_count = 0;
  decoded_char_board  board = new();

  utf8_char_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: check each accepted item, then pick the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) board.check_char(m_axis_tdata_o);
      m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  function automatic char_window_t window6(input logic [7:0] b0, b1, b2, b3, b4, b5,
                                           input logic [2:0] avail);
    char_window_t w;
    w = '0;
    w.octet = {b5, b4, b3, b2, b1, b0};
    w.available_bytes = avail;
    return w;
  endfunction

  // Mostly well-formed sequences; the rest are short, broken or pure noise.
  function automatic char_window_t random_window();
    char_window_t w;
    int unsigned  pick;
    int unsigned  n;
    int unsigned  bad;
    int unsigned  top;
    w = '0;
    for (int i = 0; i < 6; i++) w.octet[i] = 8'($urandom);
    pick = $urandom_range(0, 99);
    n = $urandom_range(1, 6);
    if (pick < 85) begin
      if (n == 1) begin
        w.octet[0][7] = 1'b0;
      end else begin
        w.octet[0] = (8'hFF << (8 - n)) | (w.octet[0] & (8'hFF >> (n + 1)));
      end
      for (int i = 1; i < n; i++) w.octet[i][7:6] = 2'b10;
      w.available_bytes = 3'($urandom_range(n, 7));
      if (pick >= 65 && pick < 75) begin
        w.available_bytes = 3'($urandom_range(0, n - 1));
      end else if (pick >= 75 && n > 1) begin
        bad = $urandom_range(1, n - 1);
        top = $urandom_range(0, 2);
        w.octet[bad][7:6] = (top == 2) ? 2'b11 : 2'(top);
      end
    end else begin
      w.available_bytes = 3'($urandom_range(0, 7));
    end
    return w;
  endfunction

  // Offer one item after a random gap and hold it until it is taken.
  task automatic push_window(input char_window_t w);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= w;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_window(w);
  endtask

  // Hold off the sender until every outstanding character has come back.
  task automatic drain_chars();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_chars.size() != 0);
  endtask

  task automatic push_random(input int unsigned count);
    for (int i = 0; i < count; i++) push_window(random_window());
    drain_chars();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ASCII extremes, and ASCII with no bytes available.
    push_window(window6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1));
    push_window(window6(8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd6));
    push_window(window6(8'h41, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd0));
    // Smallest and largest payload for every multi-byte sequence length.
    push_window(window6(8'hC0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    push_window(window6(8'hDF, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    push_window(window6(8'hE0, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3));
    push_window(window6(8'hEF, 8'hBF, 8'hBF, 8'h00, 8'h00, 8'h00, 3'd3));
    push_window(window6(8'hF0, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 3'd4));
    push_window(window6(8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00, 8'h00, 3'd4));
    push_window(window6(8'hF8, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 3'd5));
    push_window(window6(8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00, 3'd5));
    push_window(window6(8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
    push_window(window6(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6));
    // A count of seven behaves as six.
    push_window(window6(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd7));
    // Lead bytes that start no sequence.
    push_window(window6(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
    push_window(window6(8'hBF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
    push_window(window6(8'hFE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
    push_window(window6(8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd7));
    // Continuation bytes of the wrong form.
    push_window(window6(8'hE2, 8'h82, 8'hC0, 8'h00, 8'h00, 8'h00, 3'd3));
    push_window(window6(8'hE2, 8'h02, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd3));
    push_window(window6(8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h7F, 3'd6));
    // Too few bytes for the sequence.
    push_window(window6(8'hC3, 8'hA9, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1));
    push_window(window6(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd5));
    // Bytes past the sequence are ignored.
    push_window(window6(8'hC3, 8'hA9, 8'hFF, 8'h00, 8'hFE, 8'h7F, 3'd6));
    drain_chars();

    push_random(270);
    src_idle_pct  = 73;
    sink_idle_pct = 22;
    push_random(270);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    push_random(260);

    // Let the two-stage pipeline settle before the verdict.
    repeat (4) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
